/* src/chp_pkg.sv */
// Shared types and codes for the cookie header parser.
// Used by the front, queue, back and top-level files; no dependencies.
package chp_pkg;

  // Default saturation limit of the byte offset.
  localparam longint unsigned MAX_LEN_DEF = 64'd65535;

  // Default depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Width of the reported error offset.
  localparam int unsigned OFF_W = 16;

  // Status codes.
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_EMPTY_NAME     = 3'd1;
  localparam logic [2:0] ST_INVALID_NAME   = 3'd2;
  localparam logic [2:0] ST_INVALID_SYNTAX = 3'd3;
  localparam logic [2:0] ST_INVALID_VALUE  = 3'd4;

  // Byte role codes.
  localparam logic [1:0] ROLE_OTHER = 2'd0;
  localparam logic [1:0] ROLE_NAME  = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [1:0]       byte_role;
    logic             pair_end;
    logic             pair_quoted;
    logic             done_res;
    logic [2:0]       status;
    logic [OFF_W-1:0] error_offset;
  } out_item_t;

  // A classified byte as it travels from the front to the back.
  typedef struct packed {
    logic has_byte;
    logic last;
    logic ows;
    logic tchar;
    logic octet;
    logic eq;
    logic quote;
    logic semi;
  } cls_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

/* src/chp_front.sv */
// Front part of the cookie header parser: accepts input requests and
// classifies each byte into the character classes of the grammar.
// Depends on chp_pkg.
module chp_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  chp_pkg::in_item_t  in_data,
  input  chp_pkg::q_stat_t   q_stat,
  output logic               q_push,
  output chp_pkg::cls_item_t q_wdata
);
  import chp_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  // RFC token character test.
  function automatic logic is_tchar(logic [7:0] c);
    logic alnum;
    logic punct;
    alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
            (c >= 8'h61 && c <= 8'h7a);
    punct = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
            (c == 8'h26) || (c == 8'h27) || (c == 8'h2a) || (c == 8'h2b) ||
            (c == 8'h2d) || (c == 8'h2e) || (c == 8'h5e) || (c == 8'h5f) ||
            (c == 8'h60) || (c == 8'h7c) || (c == 8'h7e);
    return alnum || punct;
  endfunction

  // Cookie-octet test.
  function automatic logic is_octet(logic [7:0] c);
    return (c == 8'h21) || (c >= 8'h23 && c <= 8'h2b) || (c >= 8'h2d && c <= 8'h3a) ||
           (c >= 8'h3c && c <= 8'h5b) || (c >= 8'h5d && c <= 8'h7e);
  endfunction

  // The front takes a request whenever the queue has room.
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // Classify the byte.
  always_comb begin
    q_wdata.has_byte = in_data.has_byte;
    q_wdata.last     = in_data.last;
    q_wdata.ows      = (in_data.data_byte == CH_SPACE) || (in_data.data_byte == CH_TAB);
    q_wdata.tchar    = is_tchar(in_data.data_byte);
    q_wdata.octet    = is_octet(in_data.data_byte);
    q_wdata.eq       = (in_data.data_byte == CH_EQ);
    q_wdata.quote    = (in_data.data_byte == CH_QUOTE);
    q_wdata.semi     = (in_data.data_byte == CH_SEMI);
  end

endmodule

/* src/chp_queue.sv */
// Short queue of classified bytes between the front and the back.
// Depends on chp_pkg.
module chp_queue #(
  parameter int unsigned DEPTH = chp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chp_pkg::cls_item_t wdata,
  input  logic               pop,
  output chp_pkg::cls_item_t rdata,
  output chp_pkg::q_stat_t   stat
);
  import chp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cls_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata          = entry_r[rd_ptr_r];
  assign stat.not_empty = (count_r != '0);
  assign stat.full      = (count_r == CNT_W'(DEPTH));

endmodule

/* src/chp_back.sv */
// Back part of the cookie header parser: the per-byte grammar state
// machine, error latch and the result register. Depends on chp_pkg.
module chp_back #(
  parameter longint unsigned MAX_LEN = chp_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               single_mode,
  input  chp_pkg::q_stat_t   q_stat,
  input  chp_pkg::cls_item_t q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output chp_pkg::out_item_t out_data
);
  import chp_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);
  localparam int unsigned PH_W  = 3;

  // Parse phases.
  localparam logic [PH_W-1:0] PH_LEAD       = 3'd0;
  localparam logic [PH_W-1:0] PH_NAME_START = 3'd1;
  localparam logic [PH_W-1:0] PH_NAME       = 3'd2;
  localparam logic [PH_W-1:0] PH_VAL_START  = 3'd3;
  localparam logic [PH_W-1:0] PH_VAL        = 3'd4;
  localparam logic [PH_W-1:0] PH_QVAL       = 3'd5;
  localparam logic [PH_W-1:0] PH_QCLOSE     = 3'd6;
  localparam logic [PH_W-1:0] PH_AFTER_SEMI = 3'd7;

  // Class flags of a plain space, used when a deferred space is judged.
  localparam cls_item_t SPACE_CLS = '{has_byte: 1'b1, last: 1'b0, ows: 1'b1,
                                      tchar: 1'b0, octet: 1'b0, eq: 1'b0,
                                      quote: 1'b0, semi: 1'b0};

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic [1:0]      role;
    logic            pe;
    logic            vq_wr;
    logic            vq_val;
    logic            fail;
    logic [2:0]      kind;
  } step_res_t;

  typedef struct packed {
    logic       pe;
    logic       fail;
    logic [2:0] kind;
  } fin_res_t;

  // Judge one byte in the given phase.
  function automatic step_res_t take_byte(logic [PH_W-1:0] ph, cls_item_t c, logic single);
    step_res_t       r;
    logic [PH_W-1:0] p;
    logic            skip;
    r    = '0;
    p    = ph;
    skip = 1'b0;
    if (ph == PH_LEAD || ph == PH_AFTER_SEMI) begin
      if (!single && c.ows) begin
        skip = 1'b1;
      end else begin
        p = PH_NAME_START;
      end
    end
    r.phase = p;
    if (!skip) begin
      unique case (p)
        PH_NAME_START: begin
          if (c.tchar) begin
            r.phase = PH_NAME;
            r.role  = ROLE_NAME;
          end else begin
            r.fail = 1'b1;
            r.kind = c.eq ? ST_EMPTY_NAME : ST_INVALID_NAME;
          end
        end
        PH_NAME: begin
          if (c.tchar) begin
            r.role = ROLE_NAME;
          end else if (c.eq) begin
            r.phase  = PH_VAL_START;
            r.vq_wr  = 1'b1;
            r.vq_val = 1'b0;
          end else begin
            r.fail = 1'b1;
            r.kind = ST_INVALID_NAME;
          end
        end
        PH_VAL_START, PH_VAL: begin
          if (p == PH_VAL_START && c.quote) begin
            r.phase  = PH_QVAL;
            r.vq_wr  = 1'b1;
            r.vq_val = 1'b1;
          end else begin
            r.phase = PH_VAL;
            if (c.octet) begin
              r.role = ROLE_VALUE;
            end else if (c.semi) begin
              if (single) begin
                r.fail = 1'b1;
                r.kind = ST_INVALID_SYNTAX;
              end else begin
                r.pe    = 1'b1;
                r.phase = PH_AFTER_SEMI;
              end
            end else begin
              r.fail = 1'b1;
              r.kind = ST_INVALID_VALUE;
            end
          end
        end
        PH_QVAL: begin
          if (c.octet) begin
            r.role = ROLE_VALUE;
          end else if (c.quote) begin
            r.phase = PH_QCLOSE;
          end else begin
            r.fail = 1'b1;
            r.kind = ST_INVALID_VALUE;
          end
        end
        default: begin
          // Closing quote seen: only a separator may follow; in single mode nothing may.
          if (c.semi) begin
            if (single) begin
              r.fail = 1'b1;
              r.kind = ST_INVALID_SYNTAX;
            end else begin
              r.pe    = 1'b1;
              r.phase = PH_AFTER_SEMI;
            end
          end else begin
            r.fail = 1'b1;
            r.kind = ST_INVALID_VALUE;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Judge the end of the text in the given phase.
  function automatic fin_res_t finish(logic [PH_W-1:0] ph, logic single);
    fin_res_t r;
    r = '0;
    unique case (ph)
      PH_LEAD: begin
        r.fail = 1'b1;
        r.kind = single ? ST_INVALID_NAME : ST_EMPTY_NAME;
      end
      PH_NAME_START: begin
        r.fail = 1'b1;
        r.kind = ST_INVALID_NAME;
      end
      PH_NAME: begin
        r.fail = 1'b1;
        r.kind = ST_INVALID_SYNTAX;
      end
      PH_VAL_START, PH_VAL, PH_QCLOSE: begin
        r.pe = 1'b1;
      end
      PH_QVAL: begin
        r.fail = 1'b1;
        r.kind = ST_INVALID_VALUE;
      end
      default: begin
        r.fail = 1'b1;
        r.kind = ST_EMPTY_NAME;
      end
    endcase
    return r;
  endfunction

  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pend_at_r, pend_at_nxt;
  logic             pend_r, pend_nxt;
  logic             vq_r, vq_nxt;
  logic [2:0]       err_kind_r, err_kind_nxt;
  logic [POS_W-1:0] err_at_r, err_at_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  step_res_t        sp_res;
  step_res_t        by_res;
  fin_res_t         fin_res;
  logic [POS_W-1:0] end_at;
  logic             pe;
  logic [1:0]       role;

  // Take the next queued byte when the result register is free or being taken.
  assign q_pop = q_stat.not_empty && (!out_valid_r || !out_stall);

  // One byte step of the grammar.
  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    pend_at_nxt  = pend_at_r;
    pend_nxt     = pend_r;
    vq_nxt       = vq_r;
    err_kind_nxt = err_kind_r;
    err_at_nxt   = err_at_r;
    sp_res       = '0;
    by_res       = '0;
    fin_res      = '0;
    end_at       = '0;
    pe           = 1'b0;
    role         = ROLE_OTHER;

    if (q_rdata.has_byte) begin
      if (err_kind_nxt == ST_OK) begin
        if (!single_mode && q_rdata.ows && phase_nxt != PH_LEAD) begin
          // Defer a run of spaces; keep the offset of its first one.
          if (!pend_nxt) begin
            pend_nxt    = 1'b1;
            pend_at_nxt = pos_r;
          end
        end else begin
          // A deferred space turned out to be inside the text.
          if (pend_nxt) begin
            pend_nxt  = 1'b0;
            sp_res    = take_byte(phase_nxt, SPACE_CLS, single_mode);
            phase_nxt = sp_res.phase;
            pe        = pe || sp_res.pe;
            if (sp_res.vq_wr) begin
              vq_nxt = sp_res.vq_val;
            end
            if (sp_res.fail) begin
              err_kind_nxt = sp_res.kind;
              err_at_nxt   = pend_at_r;
            end
          end
          if (err_kind_nxt == ST_OK) begin
            by_res    = take_byte(phase_nxt, q_rdata, single_mode);
            phase_nxt = by_res.phase;
            pe        = pe || by_res.pe;
            role      = by_res.role;
            if (by_res.vq_wr) begin
              vq_nxt = by_res.vq_val;
            end
            if (by_res.fail) begin
              err_kind_nxt = by_res.kind;
              err_at_nxt   = pos_r;
            end
          end
        end
      end
      // Byte offset saturates at the limit.
      if (pos_r != POS_W'(MAX_LEN)) begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    // End of the text: a trailing run of spaces ends it at its first offset.
    if (q_rdata.last && err_kind_nxt == ST_OK) begin
      end_at  = pend_nxt ? pend_at_nxt : pos_nxt;
      fin_res = finish(phase_nxt, single_mode);
      pe      = pe || fin_res.pe;
      if (fin_res.fail) begin
        err_kind_nxt = fin_res.kind;
        err_at_nxt   = end_at;
      end
    end

    out_data_nxt.byte_role    = role;
    out_data_nxt.pair_end     = pe;
    out_data_nxt.pair_quoted  = pe && vq_nxt;
    out_data_nxt.done_res     = q_rdata.last;
    out_data_nxt.status       = q_rdata.last ? err_kind_nxt : ST_OK;
    out_data_nxt.error_offset = (q_rdata.last && err_kind_nxt != ST_OK) ?
                                OFF_W'(err_at_nxt) : '0;

    // The last request returns the parse state to its reset value.
    if (q_rdata.last) begin
      phase_nxt    = PH_LEAD;
      pos_nxt      = '0;
      pend_at_nxt  = '0;
      pend_nxt     = 1'b0;
      vq_nxt       = 1'b0;
      err_kind_nxt = ST_OK;
      err_at_nxt   = '0;
    end
  end

  // Result register handshake.
  always_comb begin
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      pos_r       <= '0;
      pend_at_r   <= '0;
      pend_r      <= 1'b0;
      vq_r        <= 1'b0;
      err_kind_r  <= ST_OK;
      err_at_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        pend_at_r  <= pend_at_nxt;
        pend_r     <= pend_nxt;
        vq_r       <= vq_nxt;
        err_kind_r <= err_kind_nxt;
        err_at_r   <= err_at_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/cookie_header_parser.sv */
// Cookie header parser: one byte per cycle unless stalled, one result per input request.
// Path: an accepted request is written into the queue, and the byte step of the back then
// moves it from the queue into the result register, where it is offered as a result.
// Throughput: one request per cycle, unless out_stall holds the result register and the queue fills.
// Reset: synchronous, active low; clears the parse state, empties the queue,
// drops any offered result and sets header mode.
module cookie_header_parser #(
  parameter longint unsigned MAX_LEN     = chp_pkg::MAX_LEN_DEF,
  parameter int unsigned     QUEUE_DEPTH = chp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output chp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import chp_pkg::*;

  logic      single_mode_r, single_mode_nxt;
  logic      q_push;
  logic      q_pop;
  cls_item_t q_wdata;
  cls_item_t q_rdata;
  q_stat_t   q_stat;

  // Mode register, written through the configuration port.
  assign single_mode_nxt = cfg_we ? cfg_wdata : single_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_mode_r <= 1'b0;
    end else begin
      single_mode_r <= single_mode_nxt;
    end
  end

  // Front: accept and classify.
  chp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Queue between the two parts.
  chp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: grammar state machine and result register.
  chp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .single_mode (single_mode_r),
    .q_stat      (q_stat),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // The queue is never written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("queue written while full");

  // A queued byte with a free result register shows up as a result next cycle.
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.not_empty && (!out_valid || !out_stall)) |=> out_valid)
    else $error("queued byte not moved to the result register");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered after reset");
`endif

endmodule
